### sv/id_range_map_translator_assert.svh
// ----------------------------------------------------------------------------
// id_range_map_translator assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ID_RANGE_MAP_TRANSLATOR_ASSERT_SVH
`define ID_RANGE_MAP_TRANSLATOR_ASSERT_SVH

// antecedent in this cycle, consequent in the same cycle, outside reset
`define IDRMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in this cycle, consequent in the next cycle, outside reset
`define IDRMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent in this cycle, consequent in the next cycle, checked in reset too
`define IDRMT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/idrmt_pkg.sv
// ----------------------------------------------------------------------------
// idrmt_pkg
// Shared codes, widths and control/status types of the id range translator.
// ----------------------------------------------------------------------------
package idrmt_pkg;

  // table depth default
  localparam int unsigned MAX_RANGES_DEF = 8;

  // field widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IN_TDATA_W  = 4 * DATA_W;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = DATA_W;
  localparam int unsigned OUT_TUSER_W = 3;

  // action codes
  localparam logic [1:0] ACT_CLEAR     = 2'd0;
  localparam logic [1:0] ACT_APPEND    = 2'd1;
  localparam logic [1:0] ACT_TRANSLATE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // take the input item
    logic scan;   // walk the table
    logic emit;   // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic trans_go;   // incoming item is a translate with a non-empty table
    logic scan_done;  // walk finished (hit or last entry compared)
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

### sv/idrmt_ctrl.sv
// ----------------------------------------------------------------------------
// idrmt_ctrl
// Sequencer: accepts one item, runs the table walk, hands off the result.
// ----------------------------------------------------------------------------
module idrmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  idrmt_pkg::sts_t   sts,
  output idrmt_pkg::cmd_t   cmd
);
  import idrmt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.trans_go ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_SCAN: cmd.scan = 1'b1;
      S_FIN:  cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

### sv/idrmt_dp.sv
// ----------------------------------------------------------------------------
// idrmt_dp
// Range table memory, walk counter, span compare and result registers.
// ----------------------------------------------------------------------------
module idrmt_dp #(
  parameter int unsigned MAX_RANGES = idrmt_pkg::MAX_RANGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [idrmt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [idrmt_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  idrmt_pkg::cmd_t                     cmd,
  output idrmt_pkg::sts_t                     sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [idrmt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [idrmt_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import idrmt_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
  localparam int unsigned IW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned ROW_W = 3 * DATA_W;

  // input fields
  logic [DATA_W-1:0] f_ins;
  logic [DATA_W-1:0] f_outs;
  logic [DATA_W-1:0] f_span;
  logic [DATA_W-1:0] f_host;
  logic [1:0]        f_act;

  assign f_ins  = in_tdata[DATA_W-1:0];
  assign f_outs = in_tdata[2*DATA_W-1:DATA_W];
  assign f_span = in_tdata[3*DATA_W-1:2*DATA_W];
  assign f_host = in_tdata[4*DATA_W-1:3*DATA_W];
  assign f_act  = in_tuser;

  // range table, row = {span, outside, inside}
  logic [ROW_W-1:0] mem [MAX_RANGES];
  logic [ROW_W-1:0] rd_data_r;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     idx_r;
  logic              cmp_vld_r;
  logic              cmp_last_r;
  logic [DATA_W-1:0] host_r;
  logic [DATA_W-1:0] res_base_r;
  logic [DATA_W-1:0] res_off_r;
  logic              res_hit_r;
  logic [1:0]        res_stat_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_cid_r;
  logic              out_hit_r;
  logic [1:0]        out_stat_r;

  logic              full;
  logic              wr_en;
  logic              rd_en;
  logic [DATA_W:0]   diff;
  logic              match;
  logic [DATA_W-1:0] rd_ins;
  logic [DATA_W-1:0] rd_outs;
  logic [DATA_W-1:0] rd_span;

  assign full  = (count_r >= CW'(MAX_RANGES));
  assign wr_en = cmd.load && (f_act == ACT_APPEND) && (f_span != '0) && !full;
  assign rd_en = cmd.scan && (idx_r < count_r);

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IW-1:0]] <= {f_span, f_outs, f_ins};
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IW-1:0]];
    end
  end

  // span check: host in [outside, outside + span), 33 bits wide
  assign rd_ins  = rd_data_r[DATA_W-1:0];
  assign rd_outs = rd_data_r[2*DATA_W-1:DATA_W];
  assign rd_span = rd_data_r[3*DATA_W-1:2*DATA_W];
  assign diff    = {1'b0, host_r} - {1'b0, rd_outs};
  assign match   = !diff[DATA_W] && (diff[DATA_W-1:0] < rd_span);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && (f_act == ACT_CLEAR)) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load) begin
        idx_r     <= '0;
        cmp_vld_r <= 1'b0;
      end else begin
        if (rd_en) begin
          idx_r <= idx_r + CW'(1);
        end
        cmp_vld_r <= rd_en;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: item latch, walk result, output register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_last_r <= ((idx_r + CW'(1)) == count_r);
    end
    if (cmd.load) begin
      host_r <= f_host;
      case (f_act)
        ACT_TRANSLATE: begin
          res_base_r <= f_host;
          res_off_r  <= '0;
          res_hit_r  <= 1'b0;
          res_stat_r <= STAT_OK;
        end
        ACT_APPEND: begin
          res_base_r <= '0;
          res_off_r  <= '0;
          res_hit_r  <= 1'b0;
          if (f_span == '0) begin
            res_stat_r <= STAT_ZERO;
          end else if (full) begin
            res_stat_r <= STAT_FULL;
          end else begin
            res_stat_r <= STAT_OK;
          end
        end
        default: begin
          res_base_r <= '0;
          res_off_r  <= '0;
          res_hit_r  <= 1'b0;
          res_stat_r <= STAT_OK;
        end
      endcase
    end else if (cmd.scan && cmp_vld_r && match) begin
      res_base_r <= rd_ins;
      res_off_r  <= diff[DATA_W-1:0];
      res_hit_r  <= 1'b1;
    end
    if (cmd.emit) begin
      out_cid_r  <= res_base_r + res_off_r;
      out_hit_r  <= res_hit_r;
      out_stat_r <= res_stat_r;
    end
  end

  // status to controller
  assign sts.trans_go  = (f_act == ACT_TRANSLATE) && (count_r != '0);
  assign sts.scan_done = cmp_vld_r && (match || cmp_last_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cid_r;
  assign out_tuser  = {out_stat_r, out_hit_r};

endmodule

### sv/id_range_map_translator.sv
// ----------------------------------------------------------------------------
// id_range_map_translator
// Ordered table of id ranges with clear, append and first-match translate.
// ----------------------------------------------------------------------------
// Input stream: in_tuser carries the action (clear, append, translate);
// in_tdata carries inside start, outside start, length and host id.
// Every item yields exactly one result on the output stream: out_tdata is the
// container id, out_tuser holds the hit flag and the status code.
// A translate walks the stored ranges in order through the single read port
// of the range memory, one entry per cycle with registered read data, and
// stops at the first hit; with an empty table no walk is made.
// One item is in flight at a time; the next item is taken at the edge after
// the result has moved to the output register, so a result may wait there
// while the following item runs. A stalled out_tready holds the result; a
// second result then waits in the datapath and in_tready stays low.
// Reset empties the table and clears the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module id_range_map_translator #(
  parameter int unsigned MAX_RANGES = idrmt_pkg::MAX_RANGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] inside_start, [63:32] outside_start, [95:64] span_length,
  // [127:96] host_id
  input  logic [idrmt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] action
  input  logic [idrmt_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] container_id
  output logic [idrmt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] hit, [2:1] status
  output logic [idrmt_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import idrmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  idrmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and compare datapath
  idrmt_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### sv/idrmt_chk.sv
// ----------------------------------------------------------------------------
// idrmt_chk
// Port-level checks of the id range translator, bound to the top level.
// ----------------------------------------------------------------------------
`include "id_range_map_translator_assert.svh"

module idrmt_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [idrmt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [idrmt_pkg::IN_TUSER_W-1:0]   in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [idrmt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [idrmt_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  // stalled result stays offered
  `IDRMT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // one item at a time: busy right after an accept
  `IDRMT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "item taken while busy")

  // reset leaves no result pending and the input open
  `IDRMT_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid && in_tready, "not idle after reset")

endmodule

bind id_range_map_translator idrmt_chk u_idrmt_chk (.*);

### dv/idrmt_result_monitor.sv
// ----------------------------------------------------------------------------
// idrmt_result_monitor
// Watches both streams of the id range translator, keeps its own copy of the
// range table, works out the result of every accepted item and compares it
// field by field with the results that leave the block, in order.
// ----------------------------------------------------------------------------
module idrmt_result_monitor #(
  parameter int unsigned MAX_RANGES = idrmt_pkg::MAX_RANGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // [31:0] inside_start, [63:32] outside_start, [95:64] span_length,
  // [127:96] host_id
  input  logic [idrmt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [idrmt_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] container_id
  input  logic [idrmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] hit, [2:1] status
  input  logic [idrmt_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int                                mismatch_count,
  output int                                owed_count
);
  import idrmt_pkg::*;

  typedef struct packed {
    logic [31:0] container_id;
    logic        hit;
    logic [1:0]  status;
  } xlat_result_t;

  // shadow of the range table
  logic [31:0] map_inside  [MAX_RANGES];
  logic [31:0] map_outside [MAX_RANGES];
  logic [31:0] map_span    [MAX_RANGES];
  int unsigned map_count = 0;

  xlat_result_t owed_results[$];

  initial begin
    mismatch_count = 0;
    owed_count     = 0;
  end

  // apply one item to the shadow table and return the result it must give
  function automatic xlat_result_t translate_item(input logic [1:0]   act,
                                                  input logic [127:0] data);
    logic [31:0] ins;
    logic [31:0] outs;
    logic [31:0] len;
    logic [31:0] host;
    logic [32:0] lo;
    logic [32:0] hi;
    xlat_result_t r;
    ins  = data[31:0];
    outs = data[63:32];
    len  = data[95:64];
    host = data[127:96];
    r    = '0;
    case (act)
      ACT_CLEAR: begin
        map_count = 0;
      end
      ACT_APPEND: begin
        // zero length wins over a full table
        if (len == 32'd0) begin
          r.status = STAT_ZERO;
        end else if (map_count >= MAX_RANGES) begin
          r.status = STAT_FULL;
        end else begin
          map_inside[map_count]  = ins;
          map_outside[map_count] = outs;
          map_span[map_count]    = len;
          map_count++;
        end
      end
      ACT_TRANSLATE: begin
        r.container_id = host;
        // first match in insertion order; span end kept 33 bits wide
        for (int i = 0; i < MAX_RANGES; i++) begin
          if (!r.hit && i < map_count) begin
            lo = {1'b0, map_outside[i]};
            hi = lo + {1'b0, map_span[i]};
            if ({1'b0, host} >= lo && {1'b0, host} < hi) begin
              r.container_id = map_inside[i] + (host - map_outside[i]);
              r.hit          = 1'b1;
            end
          end
        end
      end
      default: begin
        // unused action: ignored, all-zero result
      end
    endcase
    return r;
  endfunction

  // input side predicts, output side compares against the oldest prediction
  always @(posedge clk) begin : watch
    xlat_result_t want;
    xlat_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        owed_results = {owed_results, translate_item(in_tuser, in_tdata)};
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser[0], out_tuser[2:1]};
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual id %h hit %b status %0d",
                   $time, got.container_id, got.hit, got.status);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.container_id !== want.container_id) begin
            $display("%0t: container_id expected %h actual %h",
                     $time, want.container_id, got.container_id);
            mismatch_count++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
            mismatch_count++;
          end
        end
      end
      owed_count = owed_results.size();
    end
  end

endmodule

### dv/tb_id_range_map_translator.sv
// ----------------------------------------------------------------------------
// tb_id_range_map_translator
// Drives clear, append and translate items into the id range translator:
// a directed opening on table edges, then random table builds with lookups
// aimed at range boundaries, under bursty input and a paced, stalling sink.
// ----------------------------------------------------------------------------
module tb_id_range_map_translator;
  import idrmt_pkg::*;

  localparam logic [1:0] ACT_NONE     = 2'd3;
  localparam int         ITEM_TARGET  = 1350;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         HOLD_CYCLES  = 400;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = ACT_CLEAR;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int mismatch_count;
  int owed_count;
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;

  // ranges appended since the last clear in the random part, for aiming lookups
  logic [31:0] seq_outs [16];
  logic [31:0] seq_span [16];
  int          seq_n;

  always #4 clk = ~clk;

  id_range_map_translator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  idrmt_result_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .owed_count     (owed_count)
  );

  // cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one item; bursts of random length with random gaps between them
  task automatic push_item(input logic [1:0]  act,
                           input logic [31:0] ins,
                           input logic [31:0] outs,
                           input logic [31:0] len,
                           input logic [31:0] host);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {host, len, outs, ins};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // span mix: mostly short, some huge, some near-full, a few zero
  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  // lookup aimed at or around one stored range
  function automatic logic [31:0] pick_host(input logic [31:0] lo,
                                            input logic [31:0] len);
    case ($urandom_range(0, 6))
      0:       return lo;
      1:       return lo + len - 32'd1;
      2:       return lo + len;
      3:       return lo - 32'd1;
      4:       return $urandom;
      default: return lo + ((len == 32'd0) ? 32'd0 : ($urandom % len));
    endcase
  endfunction

  // sink: pacing modes of random length, one long hold-off
  initial begin : sink_pacing
    int mode;
    int stretch;
    int k;
    bit hold_done;
    hold_done = 1'b0;
    k = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(16, 128);
      repeat (stretch) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((k % 5) < 3);
        endcase
        k++;
        @(posedge clk);
      end
      // long stall while the sender keeps offering, so the block backs up
      if (!hold_done && cycle_count > 700) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [31:0] lo;
    logic [31:0] len;
    int          n_app;
    int          n_look;
    int          idx;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: pass-through at both extremes
    push_item(ACT_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0);
    // unused action is ignored
    push_item(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero-length append is ignored
    push_item(ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    // full-range identity map: hit below the top id, miss at the top
    push_item(ACT_APPEND, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFE);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    push_item(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // span running past 2^32, inside result wrapping
    push_item(ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h100, 32'h0);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFF0);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFEF);
    // overlapping ranges: first match wins, end is exclusive
    push_item(ACT_APPEND, 32'h5000, 32'h1000, 32'h10, 32'h0);
    push_item(ACT_APPEND, 32'h9000, 32'h1008, 32'h100, 32'h0);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h100C);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h1010);
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h1108);
    // fill the table
    for (int k = 0; k < 5; k++) begin
      push_item(ACT_APPEND, 32'h7000_0000 + k, 32'h2000_0000 + k * 32'h1000,
                32'h1000, 32'h0);
    end
    // full table drops the range; zero length still reports as zero
    push_item(ACT_APPEND, 32'h1, 32'h3000_0000, 32'h10, 32'h0);
    push_item(ACT_APPEND, 32'h1, 32'h3000_0000, 32'h0, 32'h0);
    // hit on the last entry
    push_item(ACT_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h2000_4FFF);

    // random part: table builds followed by aimed lookups, plus noise
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 4) != 0) begin
          push_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
          seq_n = 0;
        end
        n_app = $urandom_range(0, 10);
        for (int a = 0; a < n_app; a++) begin
          lo  = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
                                            : $urandom;
          len = pick_span();
          if (seq_n < 16) begin
            seq_outs[seq_n] = lo;
            seq_span[seq_n] = len;
            seq_n++;
          end
          push_item(ACT_APPEND, $urandom, lo, len, $urandom);
        end
        n_look = $urandom_range(2, 12);
        for (int t = 0; t < n_look; t++) begin
          if (seq_n == 0) begin
            push_item(ACT_TRANSLATE, $urandom, $urandom, $urandom, $urandom);
          end else begin
            idx = $urandom_range(0, seq_n - 1);
            push_item(ACT_TRANSLATE, $urandom, $urandom, $urandom,
                      pick_host(seq_outs[idx], seq_span[idx]));
          end
        end
      end else begin
        // noise: any action, any data
        repeat ($urandom_range(1, 4)) begin
          push_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        end
      end
    end

    // drain, then watch a while for stray results
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    if (mismatch_count == 0 && owed_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
